// ===== hdl/fpfa_pkg.sv =====
`default_nettype none

package fpfa_pkg;

  // Table geometry
  localparam int MAX_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  // One table word: held amount over partition size
  localparam int RAM_W      = 2 * SIZE_BITS;

  // Interface payload widths
  localparam int CMD_W      = 2;
  localparam int VAL_W      = 16;
  localparam int STATUS_W   = 3;
  localparam int SLOT_W     = 4;
  localparam int SSIZE_W    = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_FIRST = 2'd1,
    CMD_BEST  = 2'd2,
    CMD_WORST = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED  = 3'd0,
    ST_NO_FIT     = 3'd1,
    ST_LOADED     = 3'd2,
    ST_TABLE_FULL = 3'd3,
    ST_ZERO_REQ   = 3'd4
  } status_t;

  // Finished result handed from the sequencer to the output register
  typedef struct packed {
    logic                  valid;
    status_t               status;
    logic [SLOT_W-1:0]     slot;
    logic [SSIZE_W-1:0]    size;
  } res_t;

  // Table memory access
  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [RAM_W-1:0]      wdata;
    logic [IDX_W-1:0]      raddr;
  } ram_req_t;

endpackage

`default_nettype wire

// ===== hdl/fpfa_if.sv =====
`default_nettype none

// Command channel
interface fpfa_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [fpfa_pkg::CMD_W-1:0]   command;
  logic [fpfa_pkg::VAL_W-1:0]   size_value;

  modport source (output valid, output command, output size_value, input ready);
  modport sink   (input valid, input command, input size_value, output ready);
endinterface

// Result channel
interface fpfa_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [fpfa_pkg::STATUS_W-1:0]  status;
  logic [fpfa_pkg::SLOT_W-1:0]    slot_index;
  logic [fpfa_pkg::SSIZE_W-1:0]   slot_size;

  modport source (output valid, output status, output slot_index, output slot_size,
                  input ready);
  modport sink   (input valid, input status, input slot_index, input slot_size,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/fixed_partition_fit_allocator_core.sv =====
`default_nettype none
// Fixed-partition fit allocator.
// cmd channel: command (load, first fit, best fit, worst fit) and size_value.
// rsp channel: status, slot_index, slot_size; exactly one result per item.
// Partition sizes and held amounts share one 16-entry table RAM with a
// registered read; a single sequencer reads, compares and writes back.
// Steps from accept to result valid:
//   load, zero request, or allocate on an empty table: result registered on accept.
//   allocate: a scan over N entries (N = entries visited, up to the partition
//   count; first fit stops at its match), then a write-back if a match is found.
// One item is worked on at a time; the next is accepted once the result has
// moved to the output register, so it may enter while that result is stalled.
// If the receiver holds ready low, the result stays in the output register and
// the sequencer waits once it has a second result ready.
// Reset (rst, synchronous) empties the table and drops any pending result;
// no clearing pass is needed, only loaded entries are ever scanned.

module fixed_partition_fit_allocator_core (
  input wire logic clk,
  input wire logic rst,
  fpfa_cmd_if.sink   cmd,
  fpfa_rsp_if.source rsp
);

  fpfa_pkg::res_t                 res;
  fpfa_pkg::ram_req_t             ram_req;
  logic [fpfa_pkg::RAM_W-1:0]     rd_data;
  logic                           take;
  logic                           out_valid;
  fpfa_pkg::status_t              out_status;
  logic [fpfa_pkg::SLOT_W-1:0]    out_slot;
  logic [fpfa_pkg::SSIZE_W-1:0]   out_size;

  fpfa_ram #(
    .WIDTH (fpfa_pkg::RAM_W),
    .DEPTH (fpfa_pkg::MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (rd_data)
  );

  fpfa_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .take    (take),
    .res     (res),
    .ram_req (ram_req),
    .rd_data (rd_data)
  );

  // Output register: load whenever empty or being drained
  assign take = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res.valid) begin
      out_status <= res.status;
      out_slot   <= res.slot;
      out_size   <= res.size;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.slot_index = out_slot;
  assign rsp.slot_size  = out_size;

endmodule

`default_nettype wire

// ===== hdl/fpfa_ram.sv =====
`default_nettype none

module fpfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/fpfa_ctrl.sv =====
`default_nettype none

module fpfa_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  fpfa_cmd_if.sink                         cmd,
  input  wire logic                        take,
  output fpfa_pkg::res_t                   res,
  output fpfa_pkg::ram_req_t               ram_req,
  input  wire logic [fpfa_pkg::RAM_W-1:0]  rd_data
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

  state_t                             state;
  logic [fpfa_pkg::CNT_W-1:0]         count;
  logic [fpfa_pkg::IDX_W-1:0]         ptr;
  fpfa_pkg::cmd_t                     op;
  logic [fpfa_pkg::SIZE_BITS-1:0]     val;
  logic                               found;
  logic [fpfa_pkg::IDX_W-1:0]         pick;
  logic [fpfa_pkg::SIZE_BITS-1:0]     pick_size;
  fpfa_pkg::status_t                  r_status;
  logic [fpfa_pkg::SLOT_W-1:0]        r_slot;
  logic [fpfa_pkg::SSIZE_W-1:0]       r_size;

  fpfa_pkg::cmd_t                     in_op;
  logic [fpfa_pkg::SIZE_BITS-1:0]     in_val;
  logic                               accept;
  logic                               full;
  logic [fpfa_pkg::SIZE_BITS-1:0]     ent_size;
  logic [fpfa_pkg::SIZE_BITS-1:0]     ent_held;
  logic                               elig;
  logic                               better;
  logic                               take_ent;
  logic                               hit;
  logic                               last;

  // Hold off new items while in reset or busy
  assign cmd.ready = (state == S_IDLE) && !rst;
  assign accept    = cmd.valid && (state == S_IDLE) && !rst;
  assign in_op     = fpfa_pkg::cmd_t'(cmd.command);
  assign in_val    = cmd.size_value[fpfa_pkg::SIZE_BITS-1:0];
  assign full      = (count == fpfa_pkg::CNT_W'(fpfa_pkg::MAX_BLOCKS));

  // Judge the entry read in the previous cycle
  assign ent_size = rd_data[fpfa_pkg::SIZE_BITS-1:0];
  assign ent_held = rd_data[fpfa_pkg::RAM_W-1:fpfa_pkg::SIZE_BITS];
  assign elig     = (ent_held == '0) && (ent_size >= val);
  assign better   = !found
                    || ((op == fpfa_pkg::CMD_BEST)  && (ent_size < pick_size))
                    || ((op == fpfa_pkg::CMD_WORST) && (ent_size > pick_size));
  assign take_ent = elig && better;
  assign hit      = found || take_ent;
  assign last     = ({1'b0, ptr} == fpfa_pkg::CNT_W'(count - fpfa_pkg::CNT_W'(1)))
                    || ((op == fpfa_pkg::CMD_FIRST) && elig);

  // Table accesses: load writes a fresh free entry, allocate marks the pick
  always_comb begin
    ram_req.raddr = (state == S_IDLE) ? '0 : fpfa_pkg::IDX_W'(ptr + fpfa_pkg::IDX_W'(1));
    ram_req.we    = 1'b0;
    ram_req.waddr = pick;
    ram_req.wdata = {val, pick_size};
    if (accept && (in_op == fpfa_pkg::CMD_LOAD) && !full) begin
      ram_req.we    = 1'b1;
      ram_req.waddr = count[fpfa_pkg::IDX_W-1:0];
      ram_req.wdata = {{fpfa_pkg::SIZE_BITS{1'b0}}, in_val};
    end else if (state == S_WRITE) begin
      ram_req.we = 1'b1;
    end
  end

  assign res.valid  = (state == S_RESP);
  assign res.status = r_status;
  assign res.slot   = r_slot;
  assign res.size   = r_size;

  // Control sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            op  <= in_op;
            val <= in_val;
            if (in_op == fpfa_pkg::CMD_LOAD) begin
              state <= S_RESP;
              if (full) begin
                r_status <= fpfa_pkg::ST_TABLE_FULL;
                r_slot   <= '0;
                r_size   <= '0;
              end else begin
                r_status <= fpfa_pkg::ST_LOADED;
                r_slot   <= fpfa_pkg::SLOT_W'(count[fpfa_pkg::IDX_W-1:0]);
                r_size   <= fpfa_pkg::SSIZE_W'(in_val);
                count    <= fpfa_pkg::CNT_W'(count + fpfa_pkg::CNT_W'(1));
              end
            end else if (in_val == '0) begin
              state    <= S_RESP;
              r_status <= fpfa_pkg::ST_ZERO_REQ;
              r_slot   <= '0;
              r_size   <= '0;
            end else if (count == '0) begin
              state    <= S_RESP;
              r_status <= fpfa_pkg::ST_NO_FIT;
              r_slot   <= '0;
              r_size   <= '0;
            end else begin
              state <= S_SCAN;
              ptr   <= '0;
              found <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          if (take_ent) begin
            pick      <= ptr;
            pick_size <= ent_size;
          end
          found <= hit;
          ptr   <= fpfa_pkg::IDX_W'(ptr + fpfa_pkg::IDX_W'(1));
          if (last) begin
            if (hit) begin
              state <= S_WRITE;
            end else begin
              state    <= S_RESP;
              r_status <= fpfa_pkg::ST_NO_FIT;
              r_slot   <= '0;
              r_size   <= '0;
            end
          end
        end
        S_WRITE: begin
          state    <= S_RESP;
          r_status <= fpfa_pkg::ST_ALLOCATED;
          r_slot   <= fpfa_pkg::SLOT_W'(pick);
          r_size   <= fpfa_pkg::SSIZE_W'(pick_size);
        end
        S_RESP: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/fpfa_checker.sv =====
`default_nettype none

module fpfa_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            cmd_valid,
  input wire logic                            cmd_ready,
  input wire logic                            rsp_valid,
  input wire logic                            rsp_ready,
  input wire logic [fpfa_pkg::STATUS_W-1:0]   rsp_status,
  input wire logic [fpfa_pkg::SLOT_W-1:0]     rsp_slot_index,
  input wire logic [fpfa_pkg::SSIZE_W-1:0]    rsp_slot_size
);

  // Hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  // One item in flight: no accept straight after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("second item accepted while busy");

  // Only defined status codes leave the block
  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status <= fpfa_pkg::ST_ZERO_REQ))
    else $error("undefined status code");

  // Rejections carry no partition
  a_reject: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == fpfa_pkg::ST_NO_FIT
                  || rsp_status == fpfa_pkg::ST_TABLE_FULL
                  || rsp_status == fpfa_pkg::ST_ZERO_REQ)
    |-> (rsp_slot_index == '0) && (rsp_slot_size == '0))
    else $error("rejected item reports a partition");

endmodule

bind fixed_partition_fit_allocator_core fpfa_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .cmd_valid      (cmd.valid),
  .cmd_ready      (cmd.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_status     (rsp.status),
  .rsp_slot_index (rsp.slot_index),
  .rsp_slot_size  (rsp.slot_size)
);

`default_nettype wire

// ===== verif/fpfa_outcome_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the fit allocator, keeps its own copy of the
// partition table and compares every result with the oldest prediction.
module fpfa_outcome_checker
  import fpfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  fpfa_cmd_if         cmd,
  fpfa_rsp_if         rsp,
  output int unsigned failures,
  output int unsigned outstanding,
  output int unsigned results_checked,
  output int unsigned n_alloc,
  output int unsigned n_nofit,
  output int unsigned n_loaded,
  output int unsigned n_full,
  output int unsigned n_zero
);

  typedef struct packed {
    status_t              status;
    logic [SLOT_W-1:0]    slot;
    logic [SSIZE_W-1:0]   size;
  } slot_result_t;

  // Shadow partition table
  logic [SIZE_BITS-1:0] part_size [MAX_BLOCKS];
  logic [SIZE_BITS-1:0] part_held [MAX_BLOCKS];
  int                   loaded;

  slot_result_t predicted_results [$];

  int unsigned fail_total;
  int unsigned checked_total;
  int unsigned alloc_total;
  int unsigned nofit_total;
  int unsigned loaded_total;
  int unsigned full_total;
  int unsigned zero_total;

  // Apply one command to the shadow table and return the result it gives
  function automatic slot_result_t place_request(cmd_t op, logic [SIZE_BITS-1:0] amount);
    slot_result_t res;
    int           pick;
    bit           found;
    res.status = ST_NO_FIT;
    res.slot   = '0;
    res.size   = '0;
    pick       = 0;
    found      = 1'b0;
    if (op == CMD_LOAD) begin
      if (loaded >= MAX_BLOCKS) begin
        res.status = ST_TABLE_FULL;
      end else begin
        part_size[loaded] = amount;
        part_held[loaded] = '0;
        res.status = ST_LOADED;
        res.slot   = SLOT_W'(loaded);
        res.size   = amount;
        loaded++;
      end
    end else if (amount == '0) begin
      res.status = ST_ZERO_REQ;
    end else begin
      // First fit keeps the first match; best and worst replace only on a
      // strict improvement, so ties stay with the lower index
      for (int i = 0; i < loaded; i++) begin
        if (part_held[i] == '0 && part_size[i] >= amount) begin
          if (!found) begin
            pick  = i;
            found = 1'b1;
          end else if (op == CMD_BEST && part_size[i] < part_size[pick]) begin
            pick = i;
          end else if (op == CMD_WORST && part_size[i] > part_size[pick]) begin
            pick = i;
          end
        end
      end
      if (found) begin
        part_held[pick] = amount;
        res.status = ST_ALLOCATED;
        res.slot   = SLOT_W'(pick);
        res.size   = part_size[pick];
      end
    end
    return res;
  endfunction

  // Predict on each accepted command, compare on each accepted result
  always @(posedge clk) begin
    slot_result_t want;
    if (rst) begin
      predicted_results.delete();
      loaded = 0;
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        part_held[i] = '0;
      end
      fail_total    = 0;
      checked_total = 0;
      alloc_total   = 0;
      nofit_total   = 0;
      loaded_total  = 0;
      full_total    = 0;
      zero_total    = 0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        predicted_results.push_back(place_request(cmd_t'(cmd.command),
                                                  cmd.size_value[SIZE_BITS-1:0]));
      end
      if (rsp.valid && rsp.ready) begin
        if (predicted_results.size() == 0) begin
          fail_total++;
          $display("%0t: unexpected result: expected none, got status %0d slot %0d size %0d",
                   $time, rsp.status, rsp.slot_index, rsp.slot_size);
        end else begin
          want = predicted_results.pop_front();
          checked_total++;
          if (rsp.status !== want.status) begin
            fail_total++;
            $display("%0t: status mismatch: expected %0d got %0d",
                     $time, want.status, rsp.status);
          end
          if (rsp.slot_index !== want.slot) begin
            fail_total++;
            $display("%0t: slot_index mismatch: expected %0d got %0d",
                     $time, want.slot, rsp.slot_index);
          end
          if (rsp.slot_size !== want.size) begin
            fail_total++;
            $display("%0t: slot_size mismatch: expected %0d got %0d",
                     $time, want.size, rsp.slot_size);
          end
          case (want.status)
            ST_ALLOCATED:  alloc_total++;
            ST_NO_FIT:     nofit_total++;
            ST_LOADED:     loaded_total++;
            ST_TABLE_FULL: full_total++;
            default:       zero_total++;
          endcase
        end
      end
    end
    // Hand the tallies over through registered outputs
    failures        <= fail_total;
    outstanding     <= predicted_results.size();
    results_checked <= checked_total;
    n_alloc         <= alloc_total;
    n_nofit         <= nofit_total;
    n_loaded        <= loaded_total;
    n_full          <= full_total;
    n_zero          <= zero_total;
  end

endmodule

// ===== verif/fixed_partition_fit_allocator_core_test.sv =====
`timescale 1ns / 100ps

module fixed_partition_fit_allocator_core_test;
  import fpfa_pkg::*;

  localparam int RANDOM_ITEMS = 780;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int IDLE_PCT     = 38;
  localparam int DRAIN_CYCLES = 24;

  logic        clk = 1'b0;
  logic        rst;
  int unsigned cycle_count = 0;
  int          rx_cycle = 0;
  int          items_sent;
  bit          sender_quiet;

  int unsigned failures;
  int unsigned outstanding;
  int unsigned results_checked;
  int unsigned n_alloc;
  int unsigned n_nofit;
  int unsigned n_loaded;
  int unsigned n_full;
  int unsigned n_zero;

  fpfa_cmd_if cmd_ch ();
  fpfa_rsp_if rsp_ch ();

  fixed_partition_fit_allocator_core i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  fpfa_outcome_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd_ch),
    .rsp             (rsp_ch),
    .failures        (failures),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .n_alloc         (n_alloc),
    .n_nofit         (n_nofit),
    .n_loaded        (n_loaded),
    .n_full          (n_full),
    .n_zero          (n_zero)
  );

  always #2 clk = ~clk;

  // Give up if the run hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result receiver: one long hold-off to back the block up, one stretch
  // of steady acceptance, random stalls elsewhere
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (rx_cycle >= 500 && rx_cycle < 900) begin
      rsp_ch.ready <= 1'b0;
    end else if (rx_cycle >= 3000 && rx_cycle < 5000) begin
      rsp_ch.ready <= 1'b1;
    end else begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Offer one command and hold it until the block takes it
  task automatic send_cmd(input cmd_t op, input logic [VAL_W-1:0] value);
    while (!sender_quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.command    <= op;
    cmd_ch.size_value <= value;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  initial begin
    int                roll;
    int                pick;
    logic [VAL_W-1:0]  value;
    rst               = 1'b1;
    cmd_ch.valid      = 1'b0;
    cmd_ch.command    = CMD_LOAD;
    cmd_ch.size_value = '0;
    rsp_ch.ready      = 1'b0;
    items_sent        = 0;
    sender_quiet      = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Empty table, then zero requests for every fit policy
    send_cmd(CMD_FIRST, 16'd1);
    send_cmd(CMD_BEST, 16'd0);
    send_cmd(CMD_WORST, 16'd0);
    send_cmd(CMD_FIRST, 16'd0);
    // Zero-size partition, largest size, and two pairs of equal sizes
    send_cmd(CMD_LOAD, 16'd0);
    send_cmd(CMD_LOAD, 16'hFFFF);
    send_cmd(CMD_LOAD, 16'd100);
    send_cmd(CMD_LOAD, 16'd300);
    send_cmd(CMD_LOAD, 16'd100);
    send_cmd(CMD_LOAD, 16'd300);
    // First fit skips the zero-size entry; ties go to the lower index
    send_cmd(CMD_FIRST, 16'd1);
    send_cmd(CMD_BEST, 16'd50);
    send_cmd(CMD_WORST, 16'd1);
    send_cmd(CMD_WORST, 16'd1);
    send_cmd(CMD_BEST, 16'd100);
    // Nothing free is big enough any more
    send_cmd(CMD_FIRST, 16'hFFFF);
    send_cmd(CMD_BEST, 16'd1);

    // Random mix: sparse loads so allocations meet a growing table,
    // then table-full loads once all slots are used
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sender_quiet = (n >= 300 && n < 420);
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          value = '0;
        end else if (pick < 6) begin
          value = VAL_W'($urandom_range(1, 4096));
        end else begin
          value = VAL_W'($urandom_range(0, 65535));
        end
        send_cmd(CMD_LOAD, value);
      end else if (roll < 11) begin
        send_cmd(cmd_t'($urandom_range(1, 3)), '0);
      end else begin
        if ($urandom_range(0, 9) < 6) begin
          value = VAL_W'($urandom_range(1, 4096));
        end else begin
          value = VAL_W'($urandom_range(1, 65535));
        end
        send_cmd(cmd_t'($urandom_range(1, 3)), value);
      end
    end
    cmd_ch.valid <= 1'b0;

    // Drain outstanding results, then allow for a late stray one
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d commands, checked %0d results in %0d cycles.",
             items_sent, results_checked, cycle_count);
    $display("Loads %0d, table full %0d, allocations %0d, no fit %0d, zero requests %0d.",
             n_loaded, n_full, n_alloc, n_nofit, n_zero);
    if (failures == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
